// File: hw/rtl/hfr_pkg.sv
// Shared types and constants for the half-precision reciprocal pipeline.
// No dependencies; used by the divider stage and the top level.
package hfr_pkg;

  localparam logic [15:0] SIGN_BIT      = 16'h8000;
  localparam logic [14:0] DIVIDEND      = 15'h4000;
  localparam logic [6:0]  BIAS_TWICE    = 7'sd30;
  localparam logic [6:0]  EXP_MAX       = 7'sd31;
  localparam logic [15:0] POS_INF       = 16'h7C00;
  localparam logic [15:0] POS_ZERO      = 16'h0000;
  localparam int          STEPS_PER_STG = 3;
  localparam int          DIV_STAGES    = 4;
  // quotient bits produced: first one is weight 2^14 of the full quotient
  localparam int          QUOT_W        = STEPS_PER_STG * DIV_STAGES;

  typedef struct packed {
    logic              valid;
    logic              pass;
    logic [15:0]       word;
    logic [14:0]       rem;
    logic [14:0]       divisor;
    logic [QUOT_W-1:0] quot;
  } stage_t;

endpackage

// File: hw/rtl/hfr_div_stage.sv
// One pipeline stage of the restoring divider: a few compare/subtract steps.
// Depends on hfr_pkg for the stage record.
module hfr_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  hfr_pkg::stage_t stage_in,
  output hfr_pkg::stage_t stage_out
);

  hfr_pkg::stage_t stage_nxt;
  hfr_pkg::stage_t stage_r;

  always_comb begin
    stage_nxt = stage_in;
    for (int i = 0; i < hfr_pkg::STEPS_PER_STG; i++) begin
      if (stage_nxt.rem >= stage_nxt.divisor) begin
        stage_nxt.rem  = stage_nxt.rem - stage_nxt.divisor;
        stage_nxt.quot = {stage_nxt.quot[hfr_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        stage_nxt.quot = {stage_nxt.quot[hfr_pkg::QUOT_W-2:0], 1'b0};
      end
      // divisor truncates as it shifts
      stage_nxt.divisor = {1'b0, stage_nxt.divisor[14:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.pass    <= stage_nxt.pass;
    stage_r.word    <= stage_nxt.word;
    stage_r.rem     <= stage_nxt.rem;
    stage_r.divisor <= stage_nxt.divisor;
    stage_r.quot    <= stage_nxt.quot;
  end

  assign stage_out = stage_r;

endmodule

// File: hw/rtl/half_float_reciprocal.sv
// Half-precision reciprocal: four divider stages and one normalize stage.
// An accepted request passes the four divider stages and the output register
// to its strobe; one request per cycle, pipelined (three steps per stage).
// busy is always low since the receiver cannot stall and nothing backs up.
// Synchronous reset clears all stage valid bits and the output strobe.
// Depends on hfr_pkg and hfr_div_stage.
module half_float_reciprocal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value_in,
  output logic        out_valid,
  output logic [15:0] out_value_out,
  output logic        out_reciprocal_taken
);

  hfr_pkg::stage_t stg [hfr_pkg::DIV_STAGES+1];

  assign busy = 1'b0;

  // Build the first stage record straight from the request
  always_comb begin
    stg[0].valid   = start && !busy;
    stg[0].pass    = (in_value_in == 16'h0000) || ((in_value_in & hfr_pkg::SIGN_BIT) != 16'h0);
    stg[0].word    = in_value_in;
    stg[0].rem     = hfr_pkg::DIVIDEND;
    stg[0].divisor = {1'b1, in_value_in[9:0], 4'b0000};
    stg[0].quot    = '0;
  end

  for (genvar g = 0; g < hfr_pkg::DIV_STAGES; g++) begin : g_div
    hfr_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_in (stg[g]),
      .stage_out(stg[g+1])
    );
  end

  hfr_pkg::stage_t last;
  logic [10:0]        sig;
  logic               shift;
  logic signed [6:0]  out_exp;
  logic [15:0]        value_nxt;

  logic               out_valid_r;
  logic [15:0]        out_value_out_r;
  logic               out_reciprocal_taken_r;

  assign last = stg[hfr_pkg::DIV_STAGES];

  always_comb begin
    // quotient bits 14..4 sit at quot[11:1]
    sig   = last.quot[hfr_pkg::QUOT_W-1 -: 11];
    shift = 1'b0;
    if (!sig[10]) begin
      sig   = {sig[9:0], 1'b0};
      shift = 1'b1;
    end
    out_exp = $signed(hfr_pkg::BIAS_TWICE) - $signed({2'b00, last.word[14:10]})
              - $signed({6'b0, shift});
    if (last.pass) begin
      value_nxt = last.word;
    end else if (out_exp <= 7'sd0) begin
      value_nxt = hfr_pkg::POS_ZERO;
    end else if (out_exp >= $signed(hfr_pkg::EXP_MAX)) begin
      value_nxt = hfr_pkg::POS_INF;
    end else begin
      value_nxt = {1'b0, out_exp[4:0], sig[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.valid;
    end
    out_value_out_r        <= value_nxt;
    out_reciprocal_taken_r <= !last.pass;
  end

  assign out_valid            = out_valid_r;
  assign out_value_out        = out_value_out_r;
  assign out_reciprocal_taken = out_reciprocal_taken_r;

endmodule

// File: hw/rtl/hfr_checker.sv
// Port-level checks for the half-precision reciprocal, bound to the top level.
// Depends only on the top-level ports.
module hfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [15:0] in_value_in,
  input logic        out_valid,
  input logic [15:0] out_value_out,
  input logic        out_reciprocal_taken
);

  // every request yields a strobe once it has passed through the pipeline
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("request not answered after five cycles");

  // no strobe without a matching earlier request
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 5))
    else $error("result strobe without request");

  // pass-through returns the request word unchanged
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_reciprocal_taken) |-> (out_value_out == $past(in_value_in, 5)))
    else $error("pass-through word altered");

  // a computed reciprocal is never negative
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reciprocal_taken) |-> !out_value_out[15])
    else $error("reciprocal has sign set");

endmodule

bind half_float_reciprocal hfr_checker u_hfr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_value_in         (in_value_in),
  .out_valid           (out_valid),
  .out_value_out       (out_value_out),
  .out_reciprocal_taken(out_reciprocal_taken)
);
